// ===== hdl/cpese_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact pair tracker package
// Shared constants, item types and codes for the enter / stay / exit tracker.
// ----------------------------------------------------------------------------
package cpese_pkg;

  // Sizing of the pair lists and keys.
  localparam int PAIR_CAPACITY = 32;
  localparam int INDEX_BITS    = 10;
  localparam int KEY_W         = 2 * INDEX_BITS;
  localparam int CNT_W         = $clog2(PAIR_CAPACITY + 1);
  localparam int POS_W         = $clog2(PAIR_CAPACITY);

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input commands.
  localparam logic CMD_PAIR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ENTER = 2'd0;
  localparam logic [1:0] KIND_STAY  = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  typedef struct packed {
    logic                  command;
    logic [INDEX_BITS-1:0] first_index;
    logic [INDEX_BITS-1:0] second_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            event_kind;
    logic [INDEX_BITS-1:0] out_first;
    logic [INDEX_BITS-1:0] out_second;
    logic                  overflow;
    logic                  last;
  } out_item_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic             eof;
    logic [KEY_W-1:0] key;
  } pair_cmd_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

// ===== hdl/contact_pair_enter_stay_exit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact pair enter / stay / exit tracker
// Merges each frame's sorted overlapping pairs against last frame's list and
// reports enter, stay, exit and frame-done events.
// ----------------------------------------------------------------------------
// Usage:
//   Send one frame's overlapping pairs on the in_ channel in ascending key
//   order (first index, then second index), then an end-of-frame item. A pair
//   whose key does not rise above the last accepted one is dropped silently.
//   Each pair yields exits for every stored pair of last frame below it and
//   then one enter or stay item; end of frame yields the remaining exits and
//   a done item. The final item caused by one input item has last set. A pair
//   beyond the list capacity is still reported, with overflow set, and is not
//   remembered for the next frame.
//   An accepted item passes through the queue, the command register and the
//   result register before its first result appears. The engine takes a pair
//   from the queue, emits its exits, then resolves it. While out_stall is
//   low, the single-port read of the previous-frame bank sets the pace of
//   one exit per cycle. A four-entry queue lets the input keep flowing
//   meanwhile. Reset empties both lists and the queue; no clearing pass is
//   needed. When out_stall is high the result register holds its item, the
//   engine waits, and in_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module contact_pair_enter_stay_exit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cpese_pkg::in_item_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output cpese_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import cpese_pkg::*;

  queue_status_t q_status;
  logic          q_push;
  pair_cmd_t     q_push_data;
  logic          q_pop;
  pair_cmd_t     q_pop_data;

  // Front: filters non-ascending keys and classifies the item.
  cpese_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Queue decouples the front from the merge engine.
  cpese_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  // Back: merge engine, pair banks and the result register.
  cpese_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ===== hdl/cpese_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact pair tracker front
// Accepts input items, drops pairs whose key does not ascend and forwards the
// rest as commands into the queue.
// ----------------------------------------------------------------------------
module cpese_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  cpese_pkg::in_item_t      in_data,
  output logic                     in_stall,
  input  cpese_pkg::queue_status_t q_status,
  output logic                     q_push,
  output cpese_pkg::pair_cmd_t     q_push_data
);
  import cpese_pkg::*;

  logic [KEY_W-1:0] last_key_r, last_key_nxt;
  logic             have_last_r, have_last_nxt;
  logic [KEY_W-1:0] key;
  logic             accept;
  logic             drop;

  always_comb begin
    key      = {in_data.first_index, in_data.second_index};
    in_stall = q_status.full;
    accept   = in_valid && !q_status.full;
    drop     = (in_data.command == CMD_PAIR) && have_last_r && (key <= last_key_r);
    q_push   = accept && !drop;
    q_push_data.eof = (in_data.command == CMD_END);
    q_push_data.key = key;

    last_key_nxt  = last_key_r;
    have_last_nxt = have_last_r;
    if (accept) begin
      if (in_data.command == CMD_END) begin
        last_key_nxt  = '0;
        have_last_nxt = 1'b0;
      end else if (!drop) begin
        last_key_nxt  = key;
        have_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_key_r  <= '0;
      have_last_r <= 1'b0;
    end else begin
      last_key_r  <= last_key_nxt;
      have_last_r <= have_last_nxt;
    end
  end

endmodule

// ===== hdl/cpese_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact pair tracker queue
// Short first-word-fall-through queue of classified commands.
// ----------------------------------------------------------------------------
module cpese_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  cpese_pkg::pair_cmd_t     push_data,
  input  logic                     pop,
  output cpese_pkg::pair_cmd_t     pop_data,
  output cpese_pkg::queue_status_t status
);
  import cpese_pkg::*;

  pair_cmd_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    status.full      = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
    status.not_empty = (count_r != '0);
    do_push          = push && !status.full;
    do_pop           = pop && status.not_empty;
    pop_data         = slot_r[rd_ptr_r];

    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/cpese_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact pair tracker back
// Merges queued commands against last frame's sorted list held in a banked
// memory and drives the result register.
// ----------------------------------------------------------------------------
module cpese_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cpese_pkg::queue_status_t q_status,
  input  cpese_pkg::pair_cmd_t     q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  output cpese_pkg::out_item_t     out_data,
  input  logic                     out_stall
);
  import cpese_pkg::*;

  localparam int MEM_DEPTH = 2 ** (POS_W + 1);

  // Both banks share one memory; the bank bit is the top address bit.
  logic [KEY_W-1:0] bank_mem [MEM_DEPTH];

  logic             cmd_valid_r, cmd_valid_nxt;
  pair_cmd_t        cmd_r;
  logic             bank_sel_r, bank_sel_nxt;
  logic [CNT_W-1:0] prev_count_r, prev_count_nxt;
  logic [CNT_W-1:0] read_pos_r, read_pos_nxt;
  logic [CNT_W-1:0] cur_count_r, cur_count_nxt;
  logic [KEY_W-1:0] head_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        result;
  logic             out_free;
  logic             load_out;
  logic             cmd_done;
  logic             avail;
  logic             wr_en;
  logic [POS_W:0]   wr_addr;
  logic [POS_W:0]   rd_addr;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    q_pop    = !cmd_valid_r && q_status.not_empty;
    avail    = (read_pos_r < prev_count_r);

    bank_sel_nxt   = bank_sel_r;
    prev_count_nxt = prev_count_r;
    read_pos_nxt   = read_pos_r;
    cur_count_nxt  = cur_count_r;
    wr_en          = 1'b0;
    load_out       = 1'b0;
    cmd_done       = 1'b0;
    result         = '0;

    if (cmd_valid_r && out_free) begin
      load_out = 1'b1;
      if (avail && (cmd_r.eof || (head_r < cmd_r.key))) begin
        // A stored pair below the incoming key, or left at end of frame, has ended.
        result.event_kind = KIND_EXIT;
        result.out_first  = head_r[KEY_W-1:INDEX_BITS];
        result.out_second = head_r[INDEX_BITS-1:0];
        read_pos_nxt      = read_pos_r + 1'b1;
      end else if (cmd_r.eof) begin
        result.event_kind = KIND_DONE;
        result.last       = 1'b1;
        cmd_done          = 1'b1;
        bank_sel_nxt      = !bank_sel_r;
        prev_count_nxt    = cur_count_r;
        read_pos_nxt      = '0;
        cur_count_nxt     = '0;
      end else begin
        result.event_kind = KIND_ENTER;
        if (avail && (head_r == cmd_r.key)) begin
          result.event_kind = KIND_STAY;
          read_pos_nxt      = read_pos_r + 1'b1;
        end
        if (cur_count_r < CNT_W'(PAIR_CAPACITY)) begin
          wr_en         = 1'b1;
          cur_count_nxt = cur_count_r + 1'b1;
        end else begin
          result.overflow = 1'b1;
        end
        result.out_first  = cmd_r.key[KEY_W-1:INDEX_BITS];
        result.out_second = cmd_r.key[INDEX_BITS-1:0];
        result.last       = 1'b1;
        cmd_done          = 1'b1;
      end
    end

    cmd_valid_nxt = cmd_valid_r;
    if (q_pop) begin
      cmd_valid_nxt = 1'b1;
    end else if (cmd_done) begin
      cmd_valid_nxt = 1'b0;
    end

    out_valid_nxt = load_out || (out_valid_r && out_stall);

    // The read address follows the next position, so head_r always holds
    // the previous-frame entry at the current read position.
    wr_addr = {!bank_sel_r, cur_count_r[POS_W-1:0]};
    rd_addr = {bank_sel_nxt, read_pos_nxt[POS_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_mem[wr_addr] <= cmd_r.key;
    end
    head_r <= bank_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    if (load_out) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r  <= 1'b0;
      bank_sel_r   <= 1'b0;
      prev_count_r <= '0;
      read_pos_r   <= '0;
      cur_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cmd_valid_r  <= cmd_valid_nxt;
      bank_sel_r   <= bank_sel_nxt;
      prev_count_r <= prev_count_nxt;
      read_pos_r   <= read_pos_nxt;
      cur_count_r  <= cur_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    read_pos_r <= prev_count_r)
    else $error("read position passed the end of last frame's list");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_count_r <= CNT_W'(PAIR_CAPACITY)) && (prev_count_r <= CNT_W'(PAIR_CAPACITY)))
    else $error("pair count exceeds capacity");

  a_exit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.event_kind == KIND_EXIT) |-> !out_data_r.last && !out_data_r.overflow)
    else $error("exit result carries last or overflow");

  a_pop_loads_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> cmd_valid_r)
    else $error("popped command was not held");
`endif

endmodule
